// File: rtl/lzms_pkg.sv
`timescale 1ns / 1ps
// lzms_pkg: shared widths, constants and types of the longest-match search block
// no dependencies; imported by every module under rtl
package lzms_pkg;

  localparam int ADDR_W       = 13;
  localparam int BUFFER_DEPTH = 1 << ADDR_W;
  localparam int DATA_W       = 8;
  localparam int LEN_W        = 9;
  localparam int S_TDATA_W    = 56;
  localparam int M_TDATA_W    = 24;

  localparam logic [LEN_W-1:0] MIN_MATCH = 9'd3;
  localparam logic [LEN_W-1:0] MAX_RUN   = 9'd273;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  // the two buffer addresses compared in one cycle
  typedef struct packed {
    logic [ADDR_W-1:0] cand_addr;
    logic [ADDR_W-1:0] cur_addr;
  } rd_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] position;
  } match_t;

endpackage

// File: rtl/lzms_hist_mem.sv
`timescale 1ns / 1ps
// lzms_hist_mem: history byte buffer, one write port and two registered read ports
// depends on lzms_pkg
module lzms_hist_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lzms_pkg::ADDR_W-1:0]   waddr,
  input  logic [lzms_pkg::DATA_W-1:0]   wdata,
  input  lzms_pkg::rd_req_t             rd_req,
  output logic [lzms_pkg::DATA_W-1:0]   rd_cand,
  output logic [lzms_pkg::DATA_W-1:0]   rd_cur
);
  import lzms_pkg::*;

  logic [DATA_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_cand <= mem[rd_req.cand_addr];
    rd_cur  <= mem[rd_req.cur_addr];
  end

endmodule

// File: rtl/lzms_search_ctrl.sv
`timescale 1ns / 1ps
// lzms_search_ctrl: search sequencer, compares one byte pair per cycle and keeps the best run
// depends on lzms_pkg; drives the read ports of lzms_hist_mem
module lzms_search_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lzms_pkg::ADDR_W-1:0]   search_start,
  input  logic [lzms_pkg::ADDR_W-1:0]   search_offset,
  input  logic [lzms_pkg::LEN_W-1:0]    lookahead_limit,
  input  logic [lzms_pkg::DATA_W-1:0]   rd_cand,
  input  logic [lzms_pkg::DATA_W-1:0]   rd_cur,
  output lzms_pkg::rd_req_t             rd_req,
  output logic                          busy,
  output logic                          done,
  output lzms_pkg::match_t              result
);
  import lzms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] cand, cand_next;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [ADDR_W-1:0] count, count_next;
  logic [ADDR_W-1:0] k, k_next;
  logic [LEN_W-1:0]  limit, limit_next;
  logic [LEN_W-1:0]  n, n_next;
  logic [LEN_W-1:0]  best, best_next;
  logic [ADDR_W-1:0] best_pos, best_pos_next;

  logic              eq, better;
  logic [LEN_W-1:0]  n1, len, fin_len;
  logic [ADDR_W-1:0] fin_pos, k1, n1_ext;

  assign busy = (state == ST_RUN);

  always_comb begin
    state_next    = state;
    cand_next     = cand;
    cur_next      = cur;
    count_next    = count;
    k_next        = k;
    limit_next    = limit;
    n_next        = n;
    best_next     = best;
    best_pos_next = best_pos;
    done          = 1'b0;
    result        = '0;
    rd_req.cand_addr = cand;
    rd_req.cur_addr  = cur;

    // the byte pair for (cand, n) is on the read ports while running
    eq      = (rd_cand == rd_cur);
    n1      = n + 1'b1;
    n1_ext  = {{(ADDR_W-LEN_W){1'b0}}, n1};
    k1      = k + 1'b1;
    len     = eq ? n1 : n;
    better  = (len > best);
    fin_len = better ? len : best;
    fin_pos = better ? cand : best_pos;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cand_next     = search_start;
          cur_next      = search_offset;
          count_next    = search_offset - search_start;
          k_next        = '0;
          n_next        = '0;
          best_next     = '0;
          best_pos_next = '0;
          if (lookahead_limit < MIN_MATCH) begin
            limit_next = MIN_MATCH;
          end else if (lookahead_limit > MAX_RUN) begin
            limit_next = MAX_RUN;
          end else begin
            limit_next = lookahead_limit;
          end
          rd_req.cand_addr = search_start;
          rd_req.cur_addr  = search_offset;
          // empty window answers at once
          if (search_offset == search_start) begin
            done = 1'b1;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (eq && (n1 != limit)) begin
          n_next           = n1;
          rd_req.cand_addr = cand + n1_ext;
          rd_req.cur_addr  = cur + n1_ext;
        end else begin
          best_next     = fin_len;
          best_pos_next = fin_pos;
          if ((better && (len == limit)) || (k1 == count)) begin
            done       = 1'b1;
            state_next = ST_IDLE;
            if (fin_len >= MIN_MATCH) begin
              result.length   = fin_len;
              result.position = fin_pos;
            end
          end else begin
            cand_next        = cand + 1'b1;
            k_next           = k1;
            n_next           = '0;
            rd_req.cand_addr = cand + 1'b1;
            rd_req.cur_addr  = cur;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cand     <= cand_next;
    cur      <= cur_next;
    count    <= count_next;
    k        <= k_next;
    limit    <= limit_next;
    n        <= n_next;
    best     <= best_next;
    best_pos <= best_pos_next;
  end

endmodule

// File: rtl/lz_longest_match_search_top.sv
`timescale 1ns / 1ps
// Longest-match search over an 8 KiB history buffer. A request with tuser = 0 writes one byte
// and gets no response; a request with tuser = 1 searches the candidate positions from
// search_start up to search_offset (mod 8192) and returns one response holding the longest
// run and its earliest position. The buffer has one read port pair, so a search compares one
// byte pair per cycle; a candidate is left on its first mismatch or when its run hits the
// lookahead limit, and the response is registered in the cycle after the last compare. An
// empty window answers in the cycle after the request. No request is taken while a search
// runs; a write request is taken while the previous response still waits on the output, a
// search request only in the cycle that response leaves. The user must write bytes before
// a search reads them; the block itself does not enforce this.
// depends on lzms_pkg, lzms_hist_mem, lzms_search_ctrl
module lz_longest_match_search_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // write_address[12:0], byte_value[20:13], search_start[33:21],
  // search_offset[46:34], lookahead_limit[55:47]
  input  logic [lzms_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // func[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // match_length[8:0], match_position[21:9], zero fill [23:22]
  output logic [lzms_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import lzms_pkg::*;

  logic              s_acc, is_write, start, we;
  logic              busy, done;
  rd_req_t           rd_req;
  match_t            result;
  logic [DATA_W-1:0] rd_cand, rd_cur;
  match_t            out_q;

  assign is_write = (func_t'(s_axis_tuser) == FUNC_WRITE);
  // a search may start only if the output slot will be free when it answers
  assign s_axis_tready = !busy && (is_write || !m_axis_tvalid || m_axis_tready);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign we    = s_acc && is_write;
  assign start = s_acc && !is_write;

  lzms_hist_mem u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (s_axis_tdata[12:0]),
    .wdata   (s_axis_tdata[20:13]),
    .rd_req  (rd_req),
    .rd_cand (rd_cand),
    .rd_cur  (rd_cur)
  );

  lzms_search_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .search_start    (s_axis_tdata[33:21]),
    .search_offset   (s_axis_tdata[46:34]),
    .lookahead_limit (s_axis_tdata[55:47]),
    .rd_cand         (rd_cand),
    .rd_cur          (rd_cur),
    .rd_req          (rd_req),
    .busy            (busy),
    .done            (done),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign m_axis_tdata = {{(M_TDATA_W-LEN_W-ADDR_W){1'b0}}, out_q.position, out_q.length};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> (!m_axis_tvalid || m_axis_tready))
    else $error("response overwritten before it was taken");

  a_no_request_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready)
    else $error("request accepted during a search");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.length == '0) ||
             ((result.length >= MIN_MATCH) && (result.length <= MAX_RUN)))
    else $error("match length out of range");

  a_zero_position: assert property (@(posedge clk) disable iff (rst)
    (done && (result.length == '0)) |-> (result.position == '0))
    else $error("nonzero position without a match");

endmodule
